>>> rtl/tiff_lzw_encoder_assert.svh
// ----------------------------------------------------------------------------
// TIFF LZW encoder assertion macros
// Concurrent assertion shorthands, compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef TIFF_LZW_ENCODER_ASSERT_SVH
`define TIFF_LZW_ENCODER_ASSERT_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define TLZW_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tlzw assertion failed");
// next-cycle implication
`define TLZW_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tlzw assertion failed");
`else
`define TLZW_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define TLZW_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

>>> rtl/tlzw_pkg.sv
// ----------------------------------------------------------------------------
// TIFF LZW encoder package
// Constants, dictionary entry type and sequencer state type.
// ----------------------------------------------------------------------------
package tlzw_pkg;

   // dictionary geometry
   localparam int HASH_SIZE = 9001;
   localparam int HASH_AW   = $clog2(HASH_SIZE);
   localparam int KEY_W     = 20;
   localparam int CODE_W    = 12;

   // code stream
   localparam logic [CODE_W-1:0] CODE_CLR   = 12'd256;
   localparam logic [CODE_W-1:0] CODE_END   = 12'd257;
   localparam logic [CODE_W-1:0] FIRST_FREE = 12'd258;
   localparam logic [CODE_W-1:0] FULL_MARK  = 12'd4094;
   localparam logic [3:0]        MIN_BITS   = 4'd9;
   localparam logic [3:0]        MAX_BITS   = 4'd12;
   localparam int                ACC_W      = 24;
   localparam int                BC_W       = 5;

   // ratio check
   localparam int                INTERVAL_W     = 20;
   localparam logic [19:0]       INTERVAL_RESET = 20'd10000;
   localparam logic [31:0]       RATIO_MAX      = 32'h7fffffff;
   localparam logic [31:0]       SMALL_IN_LIMIT = 32'h007fffff;
   localparam int                DIV_STEPS      = 32;
   localparam int                DIV_CNT_W      = $clog2(DIV_STEPS);

   typedef struct packed {
      logic              valid;
      logic [KEY_W-1:0]  key;
      logic [CODE_W-1:0] code;
   } tlzw_entry_type;

   typedef enum logic [9:0] {
      S_CLEAR = 10'b0000000001,
      S_IDLE  = 10'b0000000010,
      S_CHECK = 10'b0000000100,
      S_PUT   = 10'b0000001000,
      S_POST  = 10'b0000010000,
      S_DIV   = 10'b0000100000,
      S_FIN_A = 10'b0001000000,
      S_FIN_B = 10'b0010000000,
      S_FIN_C = 10'b0100000000,
      S_LAST  = 10'b1000000000
   } tlzw_state_type;

endpackage

>>> rtl/tlzw_if.sv
// ----------------------------------------------------------------------------
// TIFF LZW encoder channels
// Valid/ready channels for input bytes, output bytes and the CSR write.
// ----------------------------------------------------------------------------
interface tlzw_req_if;
   logic       valid;
   logic       ready;
   logic       cmd;
   logic [7:0] data_byte;
   modport source (output valid, cmd, data_byte, input ready);
   modport sink   (input valid, cmd, data_byte, output ready);
endinterface

interface tlzw_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       run_last;
   logic       strip_end;
   modport source (output valid, out_byte, run_last, strip_end, input ready);
   modport sink   (input valid, out_byte, run_last, strip_end, output ready);
endinterface

interface tlzw_csr_if;
   logic        valid;
   logic        ready;
   logic [19:0] ratio_check_interval;
   modport source (output valid, ratio_check_interval, input ready);
   modport sink   (input valid, ratio_check_interval, output ready);
endinterface

>>> rtl/tlzw_div.sv
// ----------------------------------------------------------------------------
// TIFF LZW ratio divider
// Restoring 32-bit unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tlzw_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] num,
   input  logic [31:0] den,
   output logic        done,
   output logic [31:0] quot
);
   import tlzw_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [31:0]          rem_ff, rem_in;
   logic [31:0]          q_ff, q_in;
   logic [31:0]          den_ff, den_in;
   logic [32:0]          trial;
   logic [32:0]          diff;

   // one shift-subtract step
   always_comb begin
      trial   = {rem_ff, q_ff[31]};
      diff    = trial - {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         q_in    = num;
         den_in  = den;
      end else if (busy_ff) begin
         if (!diff[32]) begin
            rem_in = diff[31:0];
            q_in   = {q_ff[30:0], 1'b1};
         end else begin
            rem_in = trial[31:0];
            q_in   = {q_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule

>>> rtl/tiff_lzw_encoder.sv
// ----------------------------------------------------------------------------
// TIFF LZW encoder
// LZW compressor for one strip with a hashed dictionary held in block RAM.
// ----------------------------------------------------------------------------
// A data byte that hits the dictionary on its first probe is accepted,
// compared and handed off; each further probe of the open-addressed table
// adds one more read of the dictionary RAM. A miss adds the output of one
// code (1-2 bytes, sent as the output side is ready) and a table upkeep
// step. A ratio check may add a run of the bit-serial divider, and a table
// clear adds the clear code to the output. Every table clear, every end of
// strip and reset start a sweep that clears the 9001-entry dictionary at one
// entry per cycle, during which no byte is accepted; CSR writes are always taken.
`include "tiff_lzw_encoder_assert.svh"

module tiff_lzw_encoder (
   input  logic clock,
   input  logic reset,
   tlzw_req_if.sink   req_bus,
   tlzw_rsp_if.source rsp_bus,
   tlzw_csr_if.sink   csr_bus
);
   import tlzw_pkg::*;

   // dictionary RAM
   tlzw_entry_type mem [HASH_SIZE];
   tlzw_entry_type rd_data_ff;
   tlzw_entry_type wr_data;
   logic [HASH_AW-1:0] rd_addr, wr_addr;
   logic               wr_en;

   // sequencer and coder state
   tlzw_state_type state_ff, state_in, ret_ff, ret_in;
   logic [HASH_AW-1:0]    clr_cnt_ff, clr_cnt_in;
   logic                  clear_pend_ff, clear_pend_in;
   logic [INTERVAL_W-1:0] interval_ff;
   logic [CODE_W-1:0]     prefix_ff, prefix_in;
   logic                  started_ff, started_in;
   logic [CODE_W-1:0]     nfc_ff, nfc_in;
   logic [3:0]            cw_ff, cw_in;
   logic [ACC_W-1:0]      acc_ff, acc_in;
   logic [BC_W-1:0]       bc_ff, bc_in;
   logic [31:0]           bytes_ff, bytes_in;
   logic [31:0]           bits_ff, bits_in;
   logic [31:0]           ncp_ff, ncp_in;
   logic [31:0]           last_ratio_ff, last_ratio_in;
   logic                  cmd_ff, cmd_in;
   logic [7:0]            byte_ff, byte_in;
   logic [KEY_W-1:0]      key_ff, key_in;
   logic [HASH_AW-1:0]    h_ff, h_in;
   logic [HASH_AW-1:0]    disp_ff, disp_in;
   logic [HASH_AW-1:0]    probe_ff, probe_in;
   logic                  w9_ff, w9_in;

   // output staging: held byte plus output register
   logic       held_vld_ff, held_vld_in;
   logic [7:0] held_ff, held_in;
   logic       rsp_vld_ff, rsp_vld_in;
   logic [7:0] rsp_byte_ff, rsp_byte_in;
   logic       rsp_last_ff, rsp_last_in;
   logic       rsp_end_ff, rsp_end_in;

   // put / emit / decide controls
   logic              put_go, put_zero, put_w9;
   logic [CODE_W-1:0] put_code;
   tlzw_state_type    put_ret;
   logic              emit_go, last_go;
   logic [7:0]        emit_byte;
   logic              can_push, out_free, req_acc;
   logic              decide_go;
   logic [31:0]       decide_val;

   // helpers
   logic [12:0]        h_raw;
   logic [HASH_AW-1:0] h0, h_next;
   logic [12:0]        mask13;
   logic [CODE_W-1:0]  nfc_p1;
   logic [ACC_W-1:0]   acc_sh;
   logic [BC_W-1:0]    bc_m8;
   logic               big_in;
   logic [31:0]        div_num, div_den;
   logic               div_start, div_done;
   logic [31:0]        div_quot;

   tlzw_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   // handshakes
   assign req_bus.ready = (state_ff == S_IDLE);
   assign req_acc       = req_bus.valid && (state_ff == S_IDLE);
   assign csr_bus.ready = 1'b1;
   assign out_free      = !rsp_vld_ff || rsp_bus.ready;
   assign can_push      = !held_vld_ff || out_free;

   // first probe and probe step
   assign h_raw  = {req_bus.data_byte, 5'b0} ^ {1'b0, prefix_ff};
   assign h0     = ({1'b0, h_raw} >= HASH_AW'(HASH_SIZE))
                 ? HASH_AW'({1'b0, h_raw} - HASH_AW'(HASH_SIZE))
                 : {1'b0, h_raw};
   assign h_next = (h_ff < disp_ff) ? h_ff + (HASH_AW'(HASH_SIZE) - disp_ff)
                                    : h_ff - disp_ff;

   assign mask13 = (13'd1 << cw_ff) - 13'd1;
   assign nfc_p1 = nfc_ff + 1'b1;
   assign acc_sh = acc_ff << cw_ff;
   assign bc_m8  = bc_ff - 5'd8;

   // ratio operands
   assign big_in  = bytes_ff > SMALL_IN_LIMIT;
   assign div_num = big_in ? bytes_ff : {bytes_ff[23:0], 8'b0};
   assign div_den = big_in ? {8'b0, bits_ff[31:8]} : bits_ff;

   // main sequencer
   always_comb begin
      state_in      = state_ff;
      ret_in        = ret_ff;
      clr_cnt_in    = clr_cnt_ff;
      clear_pend_in = clear_pend_ff;
      prefix_in     = prefix_ff;
      started_in    = started_ff;
      nfc_in        = nfc_ff;
      cw_in         = cw_ff;
      acc_in        = acc_ff;
      bc_in         = bc_ff;
      bytes_in      = bytes_ff;
      bits_in       = bits_ff;
      ncp_in        = ncp_ff;
      last_ratio_in = last_ratio_ff;
      cmd_in        = cmd_ff;
      byte_in       = byte_ff;
      key_in        = key_ff;
      h_in          = h_ff;
      disp_in       = disp_ff;
      probe_in      = probe_ff;
      w9_in         = w9_ff;
      rd_addr       = h_ff;
      wr_en         = 1'b0;
      wr_addr       = h_ff;
      wr_data       = '0;
      put_go        = 1'b0;
      put_zero      = 1'b0;
      put_w9        = 1'b0;
      put_code      = prefix_ff;
      put_ret       = S_LAST;
      emit_go       = 1'b0;
      emit_byte     = 8'(acc_ff >> bc_m8);
      last_go       = 1'b0;
      decide_go     = 1'b0;
      decide_val    = RATIO_MAX;
      div_start     = 1'b0;

      unique case (state_ff)
         // clear the dictionary one entry per cycle
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_cnt_ff;
            if (clr_cnt_ff == HASH_AW'(HASH_SIZE - 1)) begin
               clr_cnt_in    = '0;
               clear_pend_in = 1'b0;
               state_in      = S_IDLE;
            end else begin
               clr_cnt_in = clr_cnt_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (req_acc) begin
               cmd_in  = req_bus.cmd;
               byte_in = req_bus.data_byte;
               if (req_bus.cmd) begin
                  if (started_ff) begin
                     put_go   = 1'b1;
                     put_code = prefix_ff;
                     put_ret  = S_FIN_A;
                  end else begin
                     state_in = S_FIN_B;
                  end
               end else begin
                  bytes_in = bytes_ff + 32'd1;
                  if (!started_ff) begin
                     put_go     = 1'b1;
                     put_code   = CODE_CLR;
                     put_ret    = S_LAST;
                     prefix_in  = {4'b0, req_bus.data_byte};
                     started_in = 1'b1;
                  end else begin
                     key_in   = {req_bus.data_byte, prefix_ff};
                     h_in     = h0;
                     disp_in  = (h0 == '0) ? HASH_AW'(1) : HASH_AW'(HASH_SIZE) - h0;
                     probe_in = '0;
                     rd_addr  = h0;
                     state_in = S_CHECK;
                  end
               end
            end
         end
         // compare one probed entry; insertion write happens here and is
         // never read back within the same item
         S_CHECK: begin
            if (rd_data_ff.valid && rd_data_ff.key == key_ff) begin
               prefix_in = rd_data_ff.code;
               state_in  = S_LAST;
            end else if (!rd_data_ff.valid || probe_ff == HASH_AW'(HASH_SIZE)) begin
               if (!rd_data_ff.valid) begin
                  wr_en   = 1'b1;
                  wr_addr = h_ff;
                  wr_data = '{valid: 1'b1, key: key_ff, code: nfc_ff};
               end
               put_go    = 1'b1;
               put_code  = prefix_ff;
               put_ret   = S_POST;
               prefix_in = {4'b0, byte_ff};
               nfc_in    = nfc_p1;
            end else begin
               h_in     = h_next;
               rd_addr  = h_next;
               probe_in = probe_ff + 1'b1;
            end
         end
         // shift out whole bytes of the accumulator
         S_PUT: begin
            if (can_push) begin
               emit_go = 1'b1;
               bc_in   = bc_m8;
               if (bc_ff < 5'd16) begin
                  state_in = ret_ff;
                  if (w9_ff) begin
                     cw_in = MIN_BITS;
                     w9_in = 1'b0;
                  end
               end
            end
         end
         // table upkeep after a new code
         S_POST: begin
            if (nfc_ff == FULL_MARK) begin
               decide_go  = 1'b1;
               decide_val = '0;
            end else if ({1'b0, nfc_ff} > mask13) begin
               if (cw_ff < MAX_BITS) cw_in = cw_ff + 1'b1;
               state_in = S_LAST;
            end else if (bytes_ff >= ncp_ff) begin
               ncp_in = bytes_ff + {12'b0, interval_ff};
               if (div_den == '0) begin
                  decide_go  = 1'b1;
                  decide_val = RATIO_MAX;
               end else begin
                  div_start = 1'b1;
                  state_in  = S_DIV;
               end
            end else begin
               state_in = S_LAST;
            end
         end
         S_DIV: begin
            if (div_done) begin
               decide_go  = 1'b1;
               decide_val = div_quot;
            end
         end
         // end of strip: width upkeep after the prefix
         S_FIN_A: begin
            state_in = S_FIN_B;
            if (nfc_p1 == FULL_MARK) begin
               put_go   = 1'b1;
               put_zero = 1'b1;
               put_w9   = 1'b1;
               put_code = CODE_CLR;
               put_ret  = S_FIN_B;
            end else if ({1'b0, nfc_p1} > mask13 && cw_ff < MAX_BITS) begin
               cw_in = cw_ff + 1'b1;
            end
         end
         S_FIN_B: begin
            put_go   = 1'b1;
            put_code = CODE_END;
            put_ret  = S_FIN_C;
         end
         // pad byte and strip reset
         S_FIN_C: begin
            emit_byte = 8'(acc_ff << (5'd8 - bc_ff));
            if (bc_ff == '0 || can_push) begin
               emit_go       = (bc_ff != '0);
               prefix_in     = '0;
               started_in    = 1'b0;
               nfc_in        = FIRST_FREE;
               cw_in         = MIN_BITS;
               acc_in        = '0;
               bc_in         = '0;
               bytes_in      = '0;
               bits_in       = '0;
               ncp_in        = {12'b0, interval_ff};
               last_ratio_in = '0;
               clear_pend_in = 1'b1;
               state_in      = S_LAST;
            end
         end
         // hand off the held byte as the last of the item
         S_LAST: begin
            if (!held_vld_ff || out_free) begin
               last_go  = held_vld_ff;
               state_in = clear_pend_ff ? S_CLEAR : S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase

      // ratio verdict; a full table arrives here with zero to force a clear
      if (decide_go) begin
         if (nfc_ff == FULL_MARK || decide_val <= last_ratio_ff) begin
            clear_pend_in = 1'b1;
            last_ratio_in = '0;
            bytes_in      = '0;
            nfc_in        = FIRST_FREE;
            put_go        = 1'b1;
            put_zero      = 1'b1;
            put_w9        = 1'b1;
            put_code      = CODE_CLR;
            put_ret       = S_LAST;
         end else begin
            last_ratio_in = decide_val;
            state_in      = S_LAST;
         end
      end

      // append a code to the bit accumulator
      if (put_go) begin
         acc_in   = acc_sh | {12'b0, put_code};
         bc_in    = bc_ff + {1'b0, cw_ff};
         bits_in  = (put_zero ? 32'd0 : bits_ff) + {28'b0, cw_ff};
         w9_in    = put_w9;
         ret_in   = put_ret;
         state_in = S_PUT;
      end
   end

   // output staging next values
   always_comb begin
      held_vld_in = held_vld_ff;
      held_in     = held_ff;
      rsp_vld_in  = rsp_vld_ff && !rsp_bus.ready;
      rsp_byte_in = rsp_byte_ff;
      rsp_last_in = rsp_last_ff;
      rsp_end_in  = rsp_end_ff;
      if (last_go) begin
         rsp_vld_in  = 1'b1;
         rsp_byte_in = held_ff;
         rsp_last_in = 1'b1;
         rsp_end_in  = cmd_ff;
         held_vld_in = 1'b0;
      end else if (emit_go) begin
         if (held_vld_ff) begin
            rsp_vld_in  = 1'b1;
            rsp_byte_in = held_ff;
            rsp_last_in = 1'b0;
            rsp_end_in  = 1'b0;
         end
         held_in     = emit_byte;
         held_vld_in = 1'b1;
      end
   end

   // dictionary RAM ports
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         ret_ff        <= S_IDLE;
         clr_cnt_ff    <= '0;
         clear_pend_ff <= 1'b1;
         interval_ff   <= INTERVAL_RESET;
         prefix_ff     <= '0;
         started_ff    <= 1'b0;
         nfc_ff        <= FIRST_FREE;
         cw_ff         <= MIN_BITS;
         acc_ff        <= '0;
         bc_ff         <= '0;
         bytes_ff      <= '0;
         bits_ff       <= '0;
         ncp_ff        <= {12'b0, INTERVAL_RESET};
         last_ratio_ff <= '0;
         w9_ff         <= 1'b0;
         held_vld_ff   <= 1'b0;
         rsp_vld_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         ret_ff        <= ret_in;
         clr_cnt_ff    <= clr_cnt_in;
         clear_pend_ff <= clear_pend_in;
         if (csr_bus.valid) interval_ff <= csr_bus.ratio_check_interval;
         prefix_ff     <= prefix_in;
         started_ff    <= started_in;
         nfc_ff        <= nfc_in;
         cw_ff         <= cw_in;
         acc_ff        <= acc_in;
         bc_ff         <= bc_in;
         bytes_ff      <= bytes_in;
         bits_ff       <= bits_in;
         ncp_ff        <= ncp_in;
         last_ratio_ff <= last_ratio_in;
         w9_ff         <= w9_in;
         held_vld_ff   <= held_vld_in;
         rsp_vld_ff    <= rsp_vld_in;
      end
      cmd_ff      <= cmd_in;
      byte_ff     <= byte_in;
      key_ff      <= key_in;
      h_ff        <= h_in;
      disp_ff     <= disp_in;
      probe_ff    <= probe_in;
      held_ff     <= held_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
      rsp_end_ff  <= rsp_end_in;
   end

   assign rsp_bus.valid     = rsp_vld_ff;
   assign rsp_bus.out_byte  = rsp_byte_ff;
   assign rsp_bus.run_last  = rsp_last_ff;
   assign rsp_bus.strip_end = rsp_end_ff;

   // checks
   `TLZW_ASSERT_IMP(a_idle_no_held, clock, reset, req_acc, !held_vld_ff)
   `TLZW_ASSERT_IMP(a_end_is_last, clock, reset,
      rsp_vld_ff && rsp_end_ff, rsp_last_ff)
   `TLZW_ASSERT_IMP(a_idle_bc, clock, reset, state_ff == S_IDLE, bc_ff < 5'd8)
   `TLZW_ASSERT_IMP(a_cw_range, clock, reset, 1'b1,
      cw_ff >= MIN_BITS && cw_ff <= MAX_BITS)

endmodule

>>> verif/tiff_lzw_encoder_checker.sv
// ----------------------------------------------------------------------------
// TIFF LZW encoder checker
// Watches the byte, code and CSR channels, predicts the packed code stream
// of every accepted word and compares each output word with it in order.
// ----------------------------------------------------------------------------
module tiff_lzw_encoder_checker (
   input  logic  clock,
   input  logic  reset,
   tlzw_req_if   req_bus,
   tlzw_rsp_if   rsp_bus,
   tlzw_csr_if   csr_bus,
   output int    fail_count,
   output int    pending_count
);
   import tlzw_pkg::*;

   typedef struct {
      logic [7:0] out_byte;
      logic       run_last;
      logic       strip_end;
   } code_byte_type;

   localparam logic [20:0] KEY_VALID = 21'h100000;

   // shadow copy of the encoder state
   logic [20:0]  dict_keys  [HASH_SIZE];
   logic [11:0]  dict_codes [HASH_SIZE];
   int unsigned  interval;
   int unsigned  prefix;
   bit           started;
   int unsigned  free_code;
   int unsigned  width;
   int unsigned  acc;
   int unsigned  acc_bits;
   int unsigned  bytes_in;
   int unsigned  bits_out;
   int unsigned  check_point;
   int unsigned  last_ratio;

   code_byte_type stream_q [$];   // expected output words, oldest first
   logic [7:0]    item_bytes [$]; // bytes caused by the current input word

   function automatic void clear_dict();
      foreach (dict_keys[i]) dict_keys[i] = '0;
   endfunction

   function automatic void strip_restart();
      clear_dict();
      prefix      = 0;
      started     = 0;
      free_code   = FIRST_FREE;
      width       = MIN_BITS;
      acc         = 0;
      acc_bits    = 0;
      bytes_in    = 0;
      bits_out    = 0;
      check_point = interval;
      last_ratio  = 0;
   endfunction

   // append one code to the bit packer, MSB first
   function automatic void pack_code(int unsigned code);
      acc = ((acc << width) | (code & 32'hfff)) & 32'hffffff;
      acc_bits += width;
      item_bytes.push_back(8'(acc >> (acc_bits - 8)));
      acc_bits -= 8;
      if (acc_bits >= 8) begin
         item_bytes.push_back(8'(acc >> (acc_bits - 8)));
         acc_bits -= 8;
      end
      bits_out += width;
   endfunction

   function automatic void table_clear();
      clear_dict();
      last_ratio = 0;
      bytes_in   = 0;
      bits_out   = 0;
      free_code  = FIRST_FREE;
      pack_code(CODE_CLR);
      width = MIN_BITS;
   endfunction

   function automatic int unsigned ratio_now();
      int unsigned r;
      if (bytes_in > SMALL_IN_LIMIT) begin
         r = bits_out >> 8;
         return (r == 0) ? RATIO_MAX : bytes_in / r;
      end
      if (bits_out == 0) return RATIO_MAX;
      return (bytes_in << 8) / bits_out;
   endfunction

   function automatic void compress_byte(int unsigned c);
      int unsigned key, h, disp, rat;
      int slot;
      bit hit;
      slot = -1;
      hit  = 0;
      if (!started) begin
         pack_code(CODE_CLR);
         prefix = c;
         bytes_in++;
         started = 1;
         return;
      end
      bytes_in++;
      key = ((c << 12) + prefix) & 32'hfffff;
      h = (c << 5) ^ prefix;
      if (h >= HASH_SIZE) h -= HASH_SIZE;
      h = h % HASH_SIZE;
      if (dict_keys[h] == (KEY_VALID | key)) begin
         prefix = dict_codes[h];
         return;
      end
      if (!dict_keys[h][20]) begin
         slot = h;
      end else begin
         // secondary probing, stepping back and wrapping
         disp = (h == 0) ? 1 : HASH_SIZE - h;
         for (int i = 0; i < HASH_SIZE; i++) begin
            if (h < disp) h += HASH_SIZE - disp;
            else h -= disp;
            if (dict_keys[h] == (KEY_VALID | key)) begin
               prefix = dict_codes[h];
               hit = 1;
               break;
            end
            if (!dict_keys[h][20]) begin
               slot = h;
               break;
            end
         end
      end
      if (hit) return;
      pack_code(prefix);
      prefix = c;
      if (slot >= 0) begin
         dict_codes[slot] = 12'(free_code);
         dict_keys[slot]  = KEY_VALID | 21'(key);
      end
      free_code++;
      if (free_code == FULL_MARK) begin
         table_clear();
      end else if (free_code > (1 << width) - 1) begin
         if (width < MAX_BITS) width++;
      end else if (bytes_in >= check_point) begin
         check_point = bytes_in + interval;
         rat = ratio_now();
         if (rat <= last_ratio) table_clear();
         else last_ratio = rat;
      end
   endfunction

   function automatic void close_strip();
      int unsigned f;
      if (started) begin
         pack_code(prefix);
         f = free_code + 1;
         if (f == FULL_MARK) begin
            bits_out = 0;
            pack_code(CODE_CLR);
            width = MIN_BITS;
         end else if (f > (1 << width) - 1 && width < MAX_BITS) begin
            width++;
         end
      end
      pack_code(CODE_END);
      if (acc_bits > 0) item_bytes.push_back(8'(acc << (8 - acc_bits)));
      strip_restart();
   endfunction

   function automatic void predict_word(logic cmd, logic [7:0] b);
      code_byte_type e;
      int n;
      item_bytes.delete();
      if (cmd) close_strip();
      else compress_byte(b);
      n = (item_bytes.size() > 7) ? 7 : item_bytes.size();
      for (int k = 0; k < n; k++) begin
         e.out_byte  = item_bytes[k];
         e.run_last  = (k == n - 1);
         e.strip_end = cmd && (k == n - 1);
         stream_q.push_back(e);
      end
   endfunction

   // watch all channels at the rising edge
   always @(posedge clock) begin
      code_byte_type e;
      if (reset) begin
         interval = INTERVAL_RESET;
         strip_restart();
         check_point = INTERVAL_RESET;
         stream_q.delete();
         fail_count = 0;
      end else begin
         if (csr_bus.valid && csr_bus.ready)
            interval = csr_bus.ratio_check_interval;
         if (req_bus.valid && req_bus.ready)
            predict_word(req_bus.cmd, req_bus.data_byte);
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (stream_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected output word %h", rsp_bus.out_byte);
            end else begin
               e = stream_q.pop_front();
               if (e.out_byte !== rsp_bus.out_byte || e.run_last !== rsp_bus.run_last ||
                   e.strip_end !== rsp_bus.strip_end) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch: expected %h/%b/%b got %h/%b/%b",
                              e.out_byte, e.run_last, e.strip_end, rsp_bus.out_byte,
                              rsp_bus.run_last, rsp_bus.strip_end);
               end
            end
         end
      end
      pending_count = stream_q.size();
   end

endmodule

>>> verif/tiff_lzw_encoder_tb.sv
// ----------------------------------------------------------------------------
// TIFF LZW encoder testbench
// Drives strips of raw bytes and end-of-strip words with random gaps and
// output stalls, across several ratio check intervals; the checker compares.
// ----------------------------------------------------------------------------
module tiff_lzw_encoder_tb;
   import tlzw_pkg::*;

   logic clock = 0;
   logic reset = 1;
   int   fail_count;
   int   pending_count;
   bit   idle_on = 1;
   bit   hold_off = 0;

   tlzw_req_if req_bus ();
   tlzw_rsp_if rsp_bus ();
   tlzw_csr_if csr_bus ();

   tiff_lzw_encoder dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   tiff_lzw_encoder_checker chk (
      .clock         (clock),
      .reset         (reset),
      .req_bus       (req_bus),
      .rsp_bus       (rsp_bus),
      .csr_bus       (csr_bus),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always #4 clock = ~clock;

   initial begin
      req_bus.valid = 0;
      req_bus.cmd = 0;
      req_bus.data_byte = 0;
      rsp_bus.ready = 0;
      csr_bus.valid = 0;
      csr_bus.ratio_check_interval = 0;
   end

   // output side: random stall bursts, plus one long hold-off on request
   initial begin
      @(negedge clock);
      forever begin
         if (hold_off) begin
            rsp_bus.ready <= 0;
            repeat (400) @(negedge clock);
            hold_off = 0;
         end else if (idle_on && $urandom_range(0, 3) == 0) begin
            rsp_bus.ready <= 0;
            repeat ($urandom_range(1, 3)) @(negedge clock);
         end else begin
            rsp_bus.ready <= 1;
            @(negedge clock);
         end
      end
   end

   // send one word; called and returns at a falling edge
   task automatic send_word(logic cmd, logic [7:0] b);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_bus.valid     <= 1;
      req_bus.cmd       <= cmd;
      req_bus.data_byte <= b;
      do @(posedge clock); while (!(req_bus.valid && req_bus.ready));
      @(negedge clock);
   endtask

   // wait out all output and the dictionary sweep, then write the interval
   task automatic write_interval(logic [19:0] v);
      req_bus.valid <= 0;
      while (pending_count != 0) @(negedge clock);
      repeat (9200) @(negedge clock);
      csr_bus.valid <= 1;
      csr_bus.ratio_check_interval <= v;
      do @(posedge clock); while (!(csr_bus.valid && csr_bus.ready));
      @(negedge clock);
      csr_bus.valid <= 0;
   endtask

   // one strip of random bytes drawn from a random alphabet
   task automatic send_strip(int len);
      int span;
      logic [7:0] base;
      span = ($urandom_range(0, 2) == 0) ? 255 : $urandom_range(1, 7);
      base = 8'($urandom);
      for (int i = 0; i < len; i++)
         send_word(0, (span == 255) ? 8'($urandom) : 8'(base + $urandom_range(0, span)));
      send_word(1, 8'($urandom));
   endtask

   initial begin
      int sent;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      // directed: empty strip, extremes, repeats
      send_word(1, 8'hff);
      send_word(0, 8'h00);
      send_word(1, 8'h00);
      send_word(0, 8'hff);
      send_word(1, 8'hff);
      for (int i = 0; i < 8; i++) send_word(0, 8'haa);
      send_word(0, 8'h55);
      send_word(0, 8'hff);
      send_word(0, 8'h00);
      send_word(1, 8'h00);
      send_word(1, 8'h00);
      // smallest interval: ratio checks on nearly every miss
      write_interval(20'd1);
      for (int i = 0; i < 20; i++) send_word(0, 8'($urandom_range(0, 3)));
      send_word(1, 8'h00);
      write_interval(20'hfffff);
      send_strip(30);
      write_interval(20'($urandom_range(2, 12)));
      sent = 0;
      // random strips; the long output stall lands in the middle
      while (sent < 300) begin
         int len;
         len = $urandom_range(1, 40);
         if (sent > 120 && sent < 170) hold_off = 1;
         send_strip(len);
         sent += len + 1;
      end
      write_interval(INTERVAL_RESET);
      idle_on = 0;
      send_strip(60);
      req_bus.valid <= 0;
      while (pending_count != 0) @(negedge clock);
      repeat (200) @(negedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // every word may start a sweep of the 9001-entry dictionary
   initial begin
      #(8 * 20000000);
      $display("simulation failed");
      $finish;
   end

endmodule
